@@ design/offset_key_row_map_defines.svh @@
// Assertion macros used by the checker file of offset_key_row_map.
`ifndef OFFSET_KEY_ROW_MAP_DEFINES_SVH
`define OFFSET_KEY_ROW_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OKRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OKRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/okrm_pkg.sv @@
package okrm_pkg;

    // Operation codes of an input word; code 3 is unused and does nothing.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    // Sticky failure reasons.
    typedef enum logic [1:0] {
        FAIL_NONE    = 2'd0,
        FAIL_OFFSETS = 2'd1,
        FAIL_REPEAT  = 2'd2,
        FAIL_SPAN    = 2'd3
    } fail_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_KEY_BASE = 1'b0,
        CFG_KEY_SPAN = 1'b1
    } cfg_reg_t;

    localparam int unsigned SLOT_W = 8;
    localparam logic [SLOT_W-1:0] SLOT_EMPTY = 8'hFF;
    localparam int unsigned COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] BASE_RESET = 32'sd0;
    localparam logic [COUNT_W-1:0] SPAN_RESET = 13'd4096;

    // Controller to datapath commands.
    typedef struct packed {
        logic  capture;
        logic  clear_state;
        logic  sweep_wr;
        logic  seen_upd;
        logic  walk_start;
        logic  walk_next;
        logic  off_rd_walk;
        logic  off_rd_slot;
        logic  take_walk_idx;
        logic  append;
        logic  fail_set;
        fail_t fail_code;
        logic  slot_rd;
        logic  slot_wr;
        logic  count_inc;
        logic  set_hit;
        logic  out_load;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic failed;
        logic walk_end;
        logic off_match;
        logic store_full;
        logic idx_ok;
        logic in_seen;
        logic slot_empty;
        logic slot_usable;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/offset_key_row_map.sv @@
// Dense key-to-row join map. Each input word gives exactly one result word.
// An insert walks the offset set one entry at a time, each entry read and then
// compared, through the single read port of the offset store, appends a new
// offset if none matched, then reads the status slot and writes it if empty.
// A lookup makes two dependent reads (status slot, then offset store). A clear,
// and also reset, runs a sweep that refills the status table with the empty
// mark, one slot per cycle; no word is accepted meanwhile, but configuration
// writes are taken at any time. One item is processed at a time; the output
// register lets the next word be accepted while a result waits to be taken.
module offset_key_row_map #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_OFFSETS = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   key,
    input  logic                 key_null,
    input  logic [31:0]          row_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [31:0]          row_found,
    output logic                 build_failed,
    output logic [1:0]           fail_reason,
    output logic [okrm_pkg::COUNT_W-1:0] distinct_keys,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import okrm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    okrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .key_null (key_null),
        .status   (status),
        .cmd      (cmd)
    );

    okrm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_OFFSETS (MAX_OFFSETS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .key           (key),
        .row_index     (row_index),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .row_found     (row_found),
        .build_failed  (build_failed),
        .fail_reason   (fail_reason),
        .distinct_keys (distinct_keys)
    );

endmodule

@@ design/okrm_ctrl.sv @@
module okrm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic                  key_null,
    input  okrm_pkg::dp_status_t  status,
    output okrm_pkg::ctrl_cmd_t   cmd
);
    import okrm_pkg::*;

    typedef enum logic [12:0] {
        S_SWEEP    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_INS      = 13'b0000000000100,
        S_WALK_RD  = 13'b0000000001000,
        S_WALK_CMP = 13'b0000000010000,
        S_APPEND   = 13'b0000000100000,
        S_SPAN     = 13'b0000001000000,
        S_SLOT_CHK = 13'b0000010000000,
        S_LK       = 13'b0000100000000,
        S_LK_IDX   = 13'b0001000000000,
        S_LK_SLOT  = 13'b0010000000000,
        S_LK_OFF   = 13'b0100000000000,
        S_RES      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   res_pend_reg, res_pend_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        res_pend_next = res_pend_reg;
        cmd           = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    res_pend_next = 1'b0;
                    state_next    = res_pend_reg ? S_RES : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    case (opcode_t'(opcode))
                        OP_CLEAR:
                        begin
                            cmd.clear_state = 1'b1;
                            res_pend_next   = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        OP_INSERT:  state_next = key_null ? S_RES : S_INS;
                        OP_LOOKUP:  state_next = key_null ? S_RES : S_LK;
                        default:    state_next = S_RES;
                    endcase
                end
            end
            S_INS:
            begin
                if (status.failed)
                    state_next = S_RES;
                else
                begin
                    cmd.seen_upd   = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                if (status.walk_end)
                    state_next = S_APPEND;
                else
                begin
                    cmd.off_rd_walk = 1'b1;
                    state_next      = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                if (status.off_match)
                begin
                    cmd.take_walk_idx = 1'b1;
                    state_next        = S_SPAN;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_APPEND:
            begin
                if (status.store_full)
                begin
                    cmd.fail_set  = 1'b1;
                    cmd.fail_code = FAIL_OFFSETS;
                    state_next    = S_RES;
                end
                else
                begin
                    cmd.append = 1'b1;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (!status.idx_ok)
                begin
                    cmd.fail_set  = 1'b1;
                    cmd.fail_code = FAIL_SPAN;
                    state_next    = S_RES;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_SLOT_CHK;
                end
            end
            S_SLOT_CHK:
            begin
                if (!status.slot_empty)
                begin
                    cmd.fail_set  = 1'b1;
                    cmd.fail_code = FAIL_REPEAT;
                end
                else
                begin
                    cmd.slot_wr   = 1'b1;
                    cmd.count_inc = 1'b1;
                end
                state_next = S_RES;
            end
            S_LK:
                state_next = (status.failed || !status.in_seen) ? S_RES : S_LK_IDX;
            S_LK_IDX:
            begin
                if (!status.idx_ok)
                    state_next = S_RES;
                else
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_LK_SLOT;
                end
            end
            S_LK_SLOT:
            begin
                if (!status.slot_usable)
                    state_next = S_RES;
                else
                begin
                    cmd.off_rd_slot = 1'b1;
                    state_next      = S_LK_OFF;
                end
            end
            S_LK_OFF:
            begin
                cmd.set_hit = 1'b1;
                state_next  = S_RES;
            end
            S_RES:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State registers; reset starts with a sweep of the status table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            res_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_pend_reg <= res_pend_next;
        end
    end

endmodule

@@ design/okrm_datapath.sv @@
module okrm_datapath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_OFFSETS = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic signed [31:0]    key,
    input  logic [31:0]           row_index,
    input  okrm_pkg::ctrl_cmd_t   cmd,
    output okrm_pkg::dp_status_t  status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [31:0]           row_found,
    output logic                  build_failed,
    output logic [1:0]            fail_reason,
    output logic [okrm_pkg::COUNT_W-1:0] distinct_keys
);
    import okrm_pkg::*;

    localparam int SLOT_AW = $clog2(TABLE_DEPTH);
    localparam int OFF_AW  = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
    localparam logic [SLOT_AW-1:0] SWEEP_LAST = SLOT_AW'(TABLE_DEPTH - 1);
    localparam logic [31:0]        DEPTH_32   = 32'(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0]  MAX_OFF_8  = SLOT_W'(MAX_OFFSETS);

    // Configuration registers
    logic signed [31:0]  key_base_reg;
    logic [COUNT_W-1:0]  key_span_reg;

    // Item and map state
    logic signed [31:0]  key_reg;
    logic signed [33:0]  off_reg;
    logic signed [32:0]  idx_reg, idx_next;
    logic signed [31:0]  low_reg, high_reg;
    logic [SLOT_W-1:0]   in_use_reg;
    logic [SLOT_W-1:0]   walk_cnt_reg;
    logic [SLOT_W-1:0]   sidx_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                failed_reg;
    fail_t               code_reg;
    logic [SLOT_AW-1:0]  sweep_cnt_reg;
    logic                res_hit_reg;
    logic [31:0]         res_row_reg;

    // Output register
    logic                out_valid_reg;
    logic                hit_reg;
    logic [31:0]         row_found_reg;
    logic                failed_out_reg;
    logic [1:0]          code_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    // Memories
    logic [33:0]         off_mem [MAX_OFFSETS];
    logic [SLOT_W-1:0]   slot_mem [TABLE_DEPTH];
    logic [33:0]         off_q_reg;
    logic [SLOT_W-1:0]   slot_q_reg;
    logic [OFF_AW-1:0]   off_raddr;
    logic [SLOT_AW-1:0]  slot_waddr;
    logic [SLOT_W-1:0]   slot_wdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_base_reg <= BASE_RESET;
            key_span_reg <= SPAN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_KEY_BASE: key_base_reg <= cfg_data;
                CFG_KEY_SPAN: key_span_reg <= cfg_data[COUNT_W-1:0];
                default:      key_span_reg <= key_span_reg;
            endcase
        end
    end

    // Slot index relative to the base, registered ahead of its range check
    assign idx_next = {key_reg[31], key_reg} - {key_base_reg[31], key_base_reg};

    // Item capture and result hold
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.capture)
        begin
            key_reg <= key;
            off_reg <= $signed({2'b00, row_index}) - $signed({{2{key[31]}}, key});
        end
        if (cmd.capture)
            res_row_reg <= 32'd0;
        else if (cmd.set_hit)
            res_row_reg <= key_reg + off_q_reg[31:0];
        if (cmd.take_walk_idx)
            sidx_reg <= walk_cnt_reg;
        else if (cmd.append)
            sidx_reg <= in_use_reg;
    end

    // Map state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= KEY_MAX;
            high_reg      <= KEY_MIN;
            in_use_reg    <= '0;
            walk_cnt_reg  <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            code_reg      <= FAIL_NONE;
            sweep_cnt_reg <= '0;
            res_hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_state)
            begin
                low_reg       <= KEY_MAX;
                high_reg      <= KEY_MIN;
                in_use_reg    <= '0;
                count_reg     <= '0;
                failed_reg    <= 1'b0;
                code_reg      <= FAIL_NONE;
                sweep_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.sweep_wr)
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (cmd.seen_upd)
                begin
                    if (key_reg < low_reg)
                        low_reg <= key_reg;
                    if (key_reg > high_reg)
                        high_reg <= key_reg;
                end
                if (cmd.append)
                    in_use_reg <= in_use_reg + 1'b1;
                if (cmd.fail_set)
                begin
                    failed_reg <= 1'b1;
                    code_reg   <= cmd.fail_code;
                end
                if (cmd.count_inc && (count_reg != COUNT_MAX))
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.walk_start)
                walk_cnt_reg <= '0;
            else if (cmd.walk_next)
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            if (cmd.capture)
                res_hit_reg <= 1'b0;
            else if (cmd.set_hit)
                res_hit_reg <= 1'b1;
        end
    end

    // Offset store: walk read or lookup read, append write
    assign off_raddr = cmd.off_rd_slot ? slot_q_reg[OFF_AW-1:0] : walk_cnt_reg[OFF_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.append)
            off_mem[in_use_reg[OFF_AW-1:0]] <= off_reg;
        if (cmd.off_rd_walk || cmd.off_rd_slot)
            off_q_reg <= off_mem[off_raddr];
    end

    // Status table: sweep fill or slot write, one read port
    assign slot_waddr = cmd.sweep_wr ? sweep_cnt_reg : idx_reg[SLOT_AW-1:0];
    assign slot_wdata = cmd.sweep_wr ? SLOT_EMPTY : sidx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr || cmd.slot_wr)
            slot_mem[slot_waddr] <= slot_wdata;
        if (cmd.slot_rd)
            slot_q_reg <= slot_mem[idx_reg[SLOT_AW-1:0]];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hit_reg        <= res_hit_reg;
            row_found_reg  <= res_row_reg;
            failed_out_reg <= failed_reg;
            code_out_reg   <= code_reg;
            count_out_reg  <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign row_found     = row_found_reg;
    assign build_failed  = failed_out_reg;
    assign fail_reason   = code_out_reg;
    assign distinct_keys = count_out_reg;

    // Status back to the controller
    always_comb
    begin
        status             = '0;
        status.failed      = failed_reg;
        status.walk_end    = (walk_cnt_reg == in_use_reg);
        status.off_match   = (off_q_reg == off_reg);
        status.store_full  = (in_use_reg >= MAX_OFF_8);
        status.idx_ok      = !idx_reg[32]
                             && (idx_reg[31:0] < {19'd0, key_span_reg})
                             && (idx_reg[31:0] < DEPTH_32);
        status.in_seen     = (key_reg >= low_reg) && (key_reg <= high_reg);
        status.slot_empty  = (slot_q_reg == SLOT_EMPTY);
        status.slot_usable = (slot_q_reg < MAX_OFF_8);
        status.sweep_last  = (sweep_cnt_reg == SWEEP_LAST);
        status.out_free    = !out_valid_reg || !out_stall;
    end

endmodule

@@ design/okrm_checker.sv @@
`include "offset_key_row_map_defines.svh"

module okrm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [31:0] row_found,
    input logic        build_failed,
    input logic [1:0]  fail_reason
);
    import okrm_pkg::*;

    // A stalled result word stays and holds its payload
    `OKRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
    `OKRM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(row_found) && $stable(hit), "stalled result changed")

    // A miss reports row zero
    `OKRM_ASSERT_SAME(a_miss_zero, out_valid && !hit, row_found == 32'd0, "miss with nonzero row")

    // No hit once the map has failed
    `OKRM_ASSERT_SAME(a_hit_ok, out_valid && hit, !build_failed, "hit reported on a failed map")

    // Failure flag and reason agree
    `OKRM_ASSERT_SAME(a_reason, out_valid, build_failed == (fail_reason != FAIL_NONE), "failure flag and reason disagree")

endmodule

bind offset_key_row_map okrm_checker u_okrm_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
    import okrm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int TABLE_SLOTS = 4096;
    localparam int OFFSET_SLOTS = 255;

    // One input word and one result word
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic               key_null;
        logic [31:0]        row;
    } map_word_t;

    typedef struct packed {
        logic               hit;
        logic [31:0]        row_found;
        logic               build_failed;
        logic [1:0]         fail_reason;
        logic [COUNT_W-1:0] distinct_keys;
    } map_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = '0;
    logic signed [31:0] key = '0;
    logic               key_null = 1'b0;
    logic [31:0]        row_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic [31:0]        row_found;
    logic               build_failed;
    logic [1:0]         fail_reason;
    logic [COUNT_W-1:0] distinct_keys;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [31:0]        cfg_data = '0;

    offset_key_row_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .key           (key),
        .key_null      (key_null),
        .row_index     (row_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .row_found     (row_found),
        .build_failed  (build_failed),
        .fail_reason   (fail_reason),
        .distinct_keys (distinct_keys),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Predicted map state and register copies
    logic [SLOT_W-1:0]  slot_tag [0:TABLE_SLOTS-1];
    logic signed [33:0] off_tab [0:OFFSET_SLOTS-1];
    int                 n_offsets;
    logic signed [31:0] key_lo;
    logic signed [31:0] key_hi;
    logic [COUNT_W-1:0] ins_count;
    logic               failed;
    fail_t              fail_why;
    logic signed [31:0] base_reg;
    logic [COUNT_W-1:0] span_reg;

    map_word_t   word_q [$];
    map_answer_t answer_q [$];

    // Stimulus bookkeeping: keys placed in the current map
    logic signed [31:0] placed_keys [$];
    bit                 placed_slot [longint];
    int                 random_items = 0;
    bit                 no_idle = 1'b0;
    int                 mismatches = 0;

    map_word_t   cur_word;
    int          drv_gap = 0;
    map_answer_t want;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          held_once = 1'b0;
    int          idle_cycles = 0;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void wipe_map();
        for (int i = 0; i < TABLE_SLOTS; i++)
            slot_tag[i] = SLOT_EMPTY;
        n_offsets = 0;
        key_lo = KEY_MAX;
        key_hi = KEY_MIN;
        ins_count = '0;
        failed = 1'b0;
        fail_why = FAIL_NONE;
    endfunction

    function automatic void set_failure(fail_t why);
        failed = 1'b1;
        fail_why = why;
    endfunction

    // Apply one word to the predicted map, return the expected result word
    function automatic map_answer_t update_map(map_word_t w);
        map_answer_t        r;
        logic signed [31:0] k;
        logic [31:0]        rw;
        longint             off;
        longint             idx;
        longint             lim;
        longint             sum;
        int                 s;
        bit                 ok;
        r = '0;
        k = w.key;
        rw = w.row;
        lim = span_reg;
        if (lim > TABLE_SLOTS)
            lim = TABLE_SLOTS;
        idx = longint'(k) - longint'(base_reg);
        ok = 1'b1;
        if (w.op == OP_CLEAR)
            wipe_map();
        else if (w.op == OP_INSERT && !w.key_null && !failed)
        begin
            if (k < key_lo)
                key_lo = k;
            if (k > key_hi)
                key_hi = k;
            off = longint'(rw) - longint'(k);
            for (s = 0; s < n_offsets; s++)
                if (off_tab[s] == off)
                    break;
            // new offset: append, or fail once the store is full
            if (s == n_offsets)
            begin
                if (n_offsets >= OFFSET_SLOTS)
                begin
                    set_failure(FAIL_OFFSETS);
                    ok = 1'b0;
                end
                else
                begin
                    off_tab[s] = off[33:0];
                    n_offsets++;
                end
            end
            if (ok)
            begin
                if (idx < 0 || idx >= lim)
                    set_failure(FAIL_SPAN);
                else if (slot_tag[idx] != SLOT_EMPTY)
                    set_failure(FAIL_REPEAT);
                else
                begin
                    slot_tag[idx] = s[SLOT_W-1:0];
                    if (ins_count < COUNT_MAX)
                        ins_count++;
                end
            end
        end
        else if (w.op == OP_LOOKUP && !w.key_null && !failed)
        begin
            if (k >= key_lo && k <= key_hi && idx >= 0 && idx < lim)
            begin
                if (slot_tag[idx] != SLOT_EMPTY && slot_tag[idx] < OFFSET_SLOTS)
                begin
                    sum = longint'(k) + longint'(off_tab[slot_tag[idx]]);
                    r.hit = 1'b1;
                    r.row_found = sum[31:0];
                end
            end
        end
        r.build_failed = failed;
        r.fail_reason = fail_why;
        r.distinct_keys = ins_count;
        return r;
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver: holds a stalled word, then gap or next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                answer_q.insert(answer_q.size(), update_map(cur_word));
            if (!(in_valid && in_stall))
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    cur_word = word_q.pop_front();
                    opcode <= cur_word.op;
                    key <= cur_word.key;
                    key_null <= cur_word.key_null;
                    row_index <= cur_word.row;
                    in_valid <= 1'b1;
                    drv_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = answer_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
                    if (row_found !== want.row_found)
                        report_mismatch($sformatf("row_found got %0h want %0h",
                            row_found, want.row_found));
                    if (build_failed !== want.build_failed)
                        report_mismatch($sformatf("build_failed got %0b want %0b",
                            build_failed, want.build_failed));
                    if (fail_reason !== want.fail_reason)
                        report_mismatch($sformatf("fail_reason got %0d want %0d",
                            fail_reason, want.fail_reason));
                    if (distinct_keys !== want.distinct_keys)
                        report_mismatch($sformatf("distinct_keys got %0d want %0d",
                            distinct_keys, want.distinct_keys));
                end
                stall_left = pick_gap();
            end
            // one long hold-off while a deep backlog is queued
            if (hold_left == 0 && !held_once && word_q.size() >= 100)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted word, taken result or configuration write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL offset_key_row_map");
                $finish;
            end
        end
    end

    function automatic void push_word(logic [1:0] op, logic signed [31:0] k, logic nul,
                                      logic [31:0] rw);
        map_word_t w;
        w.op = op;
        w.key = k;
        w.key_null = nul;
        w.row = rw;
        word_q.insert(word_q.size(), w);
    endfunction

    function automatic logic signed [31:0] clamp_key(longint k);
        if (k > longint'(KEY_MAX))
            return KEY_MAX;
        if (k < longint'(KEY_MIN))
            return KEY_MIN;
        return k[31:0];
    endfunction

    function automatic longint span_slots();
        longint lim;
        lim = span_reg;
        if (lim > TABLE_SLOTS)
            lim = TABLE_SLOTS;
        return lim;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_BASE)
            base_reg = data;
        else
            span_reg = data[COUNT_W-1:0];
    endtask

    // Wait until every word is in and every result is out, then let it settle
    task automatic drain();
        do
            @(negedge clk);
        while (word_q.size() != 0 || in_valid || answer_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic void forget_placed();
        placed_keys.delete();
        placed_slot.delete();
    endfunction

    // Fill the offset store past its capacity
    task automatic overflow_phase();
        logic signed [31:0] b;
        int                 i;
        int                 j;
        b = 32'($urandom_range(0, 2000000)) - 32'sd1000000;
        no_idle = ($urandom_range(0, 3) == 0);
        write_reg(CFG_KEY_BASE, b);
        write_reg(CFG_KEY_SPAN, 32'(SPAN_RESET));
        @(negedge clk);
        forget_placed();
        push_word(OP_CLEAR, $urandom, 1'b0, $urandom);
        for (i = 0; i < 262; i++)
        begin
            push_word(OP_INSERT, b + i, 1'b0, b + 32'(5000000 + 4 * i));
            // full store but not yet failed: lookups must still hit
            if (i == OFFSET_SLOTS - 1)
                for (j = 0; j < 6; j++)
                    push_word(OP_LOOKUP, b + 32'($urandom_range(0, OFFSET_SLOTS - 1)),
                              1'b0, $urandom);
        end
        for (j = 0; j < 4; j++)
            push_word(OP_LOOKUP, b + j, 1'b0, $urandom);
        random_items += 272;
    endtask

    // Mostly well-formed inserts and lookups under a random register setting
    task automatic random_phase();
        logic signed [31:0] b;
        logic [COUNT_W-1:0] sp;
        logic [31:0]        offs [0:7];
        logic signed [31:0] kk;
        longint             lim;
        longint             idx;
        longint             k;
        int                 n;
        int                 n_offs;
        int                 kind;
        case ($urandom_range(0, 6))
            0: b = KEY_MIN;
            1: b = KEY_MAX - 32'sd100;
            2: b = KEY_MAX;
            3: b = BASE_RESET;
            4: b = 32'($urandom_range(0, 8000)) - 32'sd4000;
            default: b = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0: sp = '0;
            1: sp = 13'd1;
            2: sp = SPAN_RESET;
            3: sp = 13'($urandom_range(4097, 8191));
            default: sp = 13'($urandom_range(2, 300));
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 85)
            write_reg(CFG_KEY_BASE, b);
        if ($urandom_range(0, 99) < 85)
            write_reg(CFG_KEY_SPAN, {19'($urandom), sp});
        lim = span_slots();
        n_offs = $urandom_range(1, 8);
        for (int j = 0; j < 8; j++)
            offs[j] = $urandom;
        @(negedge clk);
        // now and then keep the old map so lookups see a moved base
        if ($urandom_range(0, 4) != 0)
        begin
            forget_placed();
            push_word(OP_CLEAR, $urandom, 1'($urandom), $urandom);
        end
        n = $urandom_range(20, 50);
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 48)
            begin
                idx = 0;
                if (lim > 0)
                begin
                    idx = $urandom_range(0, 32'(lim - 1));
                    repeat (8)
                        if (placed_slot.exists(idx))
                            idx = $urandom_range(0, 32'(lim - 1));
                end
                k = longint'(base_reg) + idx;
                kk = clamp_key(k);
                placed_slot[idx] = 1'b1;
                placed_keys.insert(placed_keys.size(), kk);
                push_word(OP_INSERT, kk, 1'b0, kk + offs[$urandom_range(0, n_offs - 1)]);
            end
            else if (kind < 78)
            begin
                if (placed_keys.size() > 0)
                    kk = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
                else
                    kk = clamp_key(longint'(base_reg) + $urandom_range(0, 32'(lim)));
                push_word(OP_LOOKUP, kk, 1'b0, $urandom);
            end
            else if (kind < 86)
            begin
                k = longint'(base_reg) - 2 + $urandom_range(0, 32'(lim + 3));
                push_word(OP_LOOKUP, clamp_key(k), 1'b0, $urandom);
            end
            else if (kind < 89)
            begin
                // repeated key
                if (placed_keys.size() > 0)
                    kk = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
                else
                    kk = base_reg;
                push_word(OP_INSERT, kk, 1'b0, $urandom);
            end
            else if (kind < 91)
            begin
                // key just outside the span
                if ($urandom_range(0, 1))
                    k = longint'(base_reg) + lim + $urandom_range(0, 3);
                else
                    k = longint'(base_reg) - 1 - $urandom_range(0, 3);
                push_word(OP_INSERT, clamp_key(k), 1'b0, $urandom);
            end
            else if (kind < 95)
            begin
                push_word($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, $urandom, 1'b1,
                          $urandom);
                random_items--;
            end
            else if (kind < 97)
            begin
                push_word(OP_UNUSED, $urandom, 1'($urandom), $urandom);
                random_items--;
            end
            else
            begin
                push_word(2'($urandom), $urandom, 1'($urandom), $urandom);
                if (word_q[$].op == OP_CLEAR)
                    forget_placed();
            end
            random_items++;
        end
    endtask

    initial
    begin
        base_reg = BASE_RESET;
        span_reg = SPAN_RESET;
        wipe_map();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset register values
        @(negedge clk);
        push_word(OP_LOOKUP, 0, 1'b0, 0);                 // empty map misses
        push_word(OP_INSERT, 0, 1'b0, 100);
        push_word(OP_LOOKUP, 0, 1'b0, 0);
        push_word(OP_INSERT, 4095, 1'b0, 32'hFFFF_FFFF);
        push_word(OP_LOOKUP, 4095, 1'b0, 0);
        push_word(OP_LOOKUP, 2000, 1'b0, 0);              // empty slot inside seen range
        push_word(OP_INSERT, 5, 1'b1, 7);                 // null key
        push_word(OP_LOOKUP, 0, 1'b1, 0);
        push_word(OP_UNUSED, 0, 1'b0, 0);
        push_word(OP_LOOKUP, 4096, 1'b0, 0);              // beyond seen range
        push_word(OP_INSERT, 4096, 1'b0, 1);              // out of span
        push_word(OP_LOOKUP, 0, 1'b0, 0);                 // misses once failed
        push_word(OP_INSERT, 1, 1'b0, 1);                 // ignored once failed
        push_word(OP_CLEAR, KEY_MIN, 1'b1, 32'hFFFF_FFFF);
        push_word(OP_INSERT, 7, 1'b0, 7);
        push_word(OP_INSERT, 7, 1'b0, 9);                 // repeated key
        push_word(OP_CLEAR, 0, 1'b0, 0);
        push_word(OP_INSERT, -1, 1'b0, 0);                // below the base
        push_word(OP_CLEAR, 0, 1'b0, 0);
        drain();

        // Key extremes with the widest span setting
        write_reg(CFG_KEY_BASE, KEY_MIN);
        write_reg(CFG_KEY_SPAN, 32'hFFFF_FFFF);
        @(negedge clk);
        push_word(OP_INSERT, KEY_MIN, 1'b0, 0);
        push_word(OP_LOOKUP, KEY_MIN, 1'b0, 0);
        push_word(OP_INSERT, KEY_MIN + 4095, 1'b0, 32'hFFFF_FFFF);
        push_word(OP_LOOKUP, KEY_MIN + 4095, 1'b0, 0);
        drain();

        // Base moved after inserts: the lookup misses outside the seen key range, the insert finds an old slot taken
        write_reg(CFG_KEY_BASE, KEY_MAX - 32'sd4095);
        @(negedge clk);
        push_word(OP_LOOKUP, KEY_MAX, 1'b0, 0);
        push_word(OP_INSERT, KEY_MAX, 1'b0, 0);
        push_word(OP_CLEAR, 0, 1'b0, 0);
        drain();

        // Zero span rejects every key
        write_reg(CFG_KEY_SPAN, 32'd0);
        @(negedge clk);
        push_word(OP_INSERT, KEY_MAX - 32'sd4095, 1'b0, 0);
        drain();

        while (random_items < 400)
        begin
            if (!held_once && random_items >= 120)
                overflow_phase();
            else
                random_phase();
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS offset_key_row_map");
        else
            $display("FAIL offset_key_row_map");
        $finish;
    end
endmodule

@@ offset_key_row_map.f @@
+incdir+design
design/okrm_pkg.sv
design/okrm_ctrl.sv
design/okrm_datapath.sv
design/offset_key_row_map.sv
design/okrm_checker.sv
tb/tb_top.sv
